/* rtl/aets_pkg.sv */
package aets_pkg;

	localparam int SCREEN_COLS = 80;
	localparam int SCREEN_ROWS = 25;
	localparam int ROW_W = 5;
	localparam int COL_W = 7;
	localparam int CELLS = SCREEN_COLS * SCREEN_ROWS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int CELL_W = 16;
	localparam int MAX_PARAMS_DEF = 4;
	localparam int PARAM_W = 10;
	localparam int PARAM_MAX = 999;

	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_BLANK = 8'h20;
	localparam logic [7:0] CH_LBRACKET = 8'h5B;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_J = 8'h4A;
	localparam logic [7:0] CH_K = 8'h4B;
	localparam logic [7:0] CH_H = 8'h48;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_M = 8'h6D;

	localparam logic [7:0] NORMAL_ATTR_RST = 8'h07;
	localparam logic [7:0] INVERSE_ATTR_RST = 8'h70;

	localparam logic CFG_NORMAL_ATTR = 1'b0;
	localparam logic CFG_INVERSE_ATTR = 1'b1;

	localparam logic OP_FEED = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic operation;
		logic [7:0] data_byte;
		logic [4:0] read_row;
		logic [6:0] read_col;
	} req_item_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [7:0] cell_attr;
		logic [4:0] cursor_row;
		logic [6:0] cursor_col;
		logic inverse_on;
	} rsp_item_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_PUT,
		CMD_CR,
		CMD_LF,
		CMD_BS,
		CMD_CLEAR,
		CMD_EL,
		CMD_CUP,
		CMD_SGR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [7:0] ch;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic inv_hit;
		logic inv;
	} cmd_t;

endpackage

/* rtl/ansi_escape_text_screen_engine_top.sv */
// Terminal text screen: bytes fed on the request channel are interpreted as
// a VT100 subset (CR, LF, backspace/DEL, printable bytes, ESC [ sequences
// J, K, H/f and m) against an 80x25 store of character/attribute cells held
// in one single-port-write, registered-read RAM; a read request returns one
// cell, and every request yields exactly one response with the cursor and
// the inverse flag. After reset the block blanks the whole RAM and takes
// no request meanwhile (configuration writes are taken). A plain byte or a
// cursor command goes through ST_RESULT before the next ready, a cell read
// through ST_READ and ST_RESULT. Scrolling rotates a row pointer and blanks
// one row; erase to end of line blanks each erased cell and a screen clear
// all 2000 cells, one RAM write per cycle in each case.
module ansi_escape_text_screen_engine_top #(
	parameter int MAX_PARAMS = aets_pkg::MAX_PARAMS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input aets_pkg::req_item_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output aets_pkg::rsp_item_t rsp,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_index,
	input logic [7:0] cfg_data
);

	logic [7:0] normal_attr_q;
	logic [7:0] inverse_attr_q;
	logic feed;
	aets_pkg::cmd_t cmd;
	logic ram_we;
	logic [aets_pkg::ADDR_W-1:0] ram_waddr;
	logic [aets_pkg::ADDR_W-1:0] ram_raddr;
	logic [aets_pkg::CELL_W-1:0] ram_wdata;
	logic [aets_pkg::CELL_W-1:0] ram_rdata;

	assign cfg_ready = 1'b1;
	assign feed = req_valid && req_ready && (req.operation == aets_pkg::OP_FEED);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_attr_q <= aets_pkg::NORMAL_ATTR_RST;
			inverse_attr_q <= aets_pkg::INVERSE_ATTR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				aets_pkg::CFG_NORMAL_ATTR: normal_attr_q <= cfg_data;
				aets_pkg::CFG_INVERSE_ATTR: inverse_attr_q <= cfg_data;
				default: normal_attr_q <= normal_attr_q;
			endcase
		end
	end

	aets_parser #(
		.MAX_PARAMS(MAX_PARAMS)
	) u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.feed(feed),
		.byte_in(req.data_byte),
		.cmd(cmd)
	);

	aets_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cmd(cmd),
		.normal_attr(normal_attr_q),
		.inverse_attr(inverse_attr_q),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	aets_ram #(
		.WIDTH(aets_pkg::CELL_W),
		.DEPTH(aets_pkg::CELLS)
	) u_screen_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

/* rtl/aets_ram.sv */
module aets_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/aets_parser.sv */
module aets_parser #(
	parameter int MAX_PARAMS = aets_pkg::MAX_PARAMS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic feed,
	input logic [7:0] byte_in,
	output aets_pkg::cmd_t cmd
);

	localparam int CNT_W = $clog2(MAX_PARAMS + 1);
	localparam int IDX_W = $clog2(MAX_PARAMS);
	localparam int PW = aets_pkg::PARAM_W;

	typedef enum logic [3:0] {
		MODE_NORMAL = 4'b0001,
		MODE_ESC = 4'b0010,
		MODE_CSI = 4'b0100,
		MODE_QMARK = 4'b1000
	} mode_t;

	mode_t mode_q, nx_mode;
	logic [PW-1:0] vals_q [MAX_PARAMS];
	logic [PW-1:0] nx_vals [MAX_PARAMS];
	logic [PW-1:0] cl_vals [MAX_PARAMS];
	logic [CNT_W-1:0] cnt_q, nx_cnt, cl_cnt;
	logic [PW-1:0] acc_q, nx_acc;
	logic active_q, nx_active;
	logic [13:0] prod;
	logic [PW-1:0] p0, p1;
	logic is_digit;

	always_comb begin
		nx_mode = mode_q;
		nx_vals = vals_q;
		nx_cnt = cnt_q;
		nx_acc = acc_q;
		nx_active = active_q;
		cmd = '0;
		cmd.kind = aets_pkg::CMD_NONE;
		cmd.ch = byte_in;

		// Parameter list as it stands once the pending digits are closed.
		cl_vals = vals_q;
		cl_cnt = cnt_q;
		if (active_q && cnt_q < CNT_W'(MAX_PARAMS)) begin
			cl_vals[cnt_q[IDX_W-1:0]] = acc_q;
			cl_cnt = cnt_q + 1'b1;
		end
		p0 = cl_vals[0];
		p1 = cl_vals[1];

		is_digit = byte_in inside {[aets_pkg::CH_ZERO:aets_pkg::CH_NINE]};
		prod = 14'(acc_q) * 14'd10 + {10'b0, byte_in[3:0]};

		case (mode_q)
			MODE_NORMAL: begin
				case (byte_in)
					aets_pkg::CH_ESC: nx_mode = MODE_ESC;
					aets_pkg::CH_CR: cmd.kind = aets_pkg::CMD_CR;
					aets_pkg::CH_LF: cmd.kind = aets_pkg::CMD_LF;
					aets_pkg::CH_BS, aets_pkg::CH_DEL: cmd.kind = aets_pkg::CMD_BS;
					default: cmd.kind = aets_pkg::CMD_PUT;
				endcase
			end
			MODE_ESC: begin
				if (byte_in == aets_pkg::CH_LBRACKET) begin
					nx_mode = MODE_CSI;
					nx_vals = '{default: '0};
					nx_cnt = '0;
					nx_acc = '0;
					nx_active = 1'b0;
				end else begin
					nx_mode = MODE_NORMAL;
				end
			end
			MODE_CSI, MODE_QMARK: begin
				if (mode_q == MODE_CSI && byte_in == aets_pkg::CH_QMARK) begin
					nx_mode = MODE_QMARK;
					nx_vals = '{default: '0};
					nx_cnt = '0;
					nx_acc = '0;
					nx_active = 1'b0;
				end else if (is_digit) begin
					nx_acc = (prod > 14'(aets_pkg::PARAM_MAX)) ? PW'(aets_pkg::PARAM_MAX)
						: prod[PW-1:0];
					nx_active = 1'b1;
				end else if (byte_in == aets_pkg::CH_SEMI) begin
					nx_vals = cl_vals;
					nx_cnt = cl_cnt;
					nx_acc = '0;
					nx_active = 1'b0;
				end else begin
					if (mode_q == MODE_CSI) begin
						case (byte_in)
							aets_pkg::CH_J: begin
								if (p0 == PW'(0) || p0 == PW'(2)) begin
									cmd.kind = aets_pkg::CMD_CLEAR;
								end
							end
							aets_pkg::CH_K: cmd.kind = aets_pkg::CMD_EL;
							aets_pkg::CH_H, aets_pkg::CH_F: begin
								cmd.kind = aets_pkg::CMD_CUP;
								if (p0 == '0) begin
									cmd.row = '0;
								end else if (p0 > PW'(aets_pkg::SCREEN_ROWS)) begin
									cmd.row = aets_pkg::ROW_W'(aets_pkg::SCREEN_ROWS - 1);
								end else begin
									cmd.row = aets_pkg::ROW_W'(p0 - 1'b1);
								end
								if (p1 == '0) begin
									cmd.col = '0;
								end else if (p1 > PW'(aets_pkg::SCREEN_COLS)) begin
									cmd.col = aets_pkg::COL_W'(aets_pkg::SCREEN_COLS - 1);
								end else begin
									cmd.col = aets_pkg::COL_W'(p1 - 1'b1);
								end
							end
							aets_pkg::CH_M: begin
								cmd.kind = aets_pkg::CMD_SGR;
								if (cl_cnt == '0) begin
									cmd.inv_hit = 1'b1;
									cmd.inv = 1'b0;
								end else begin
									// The last 0 or 7 in the list decides.
									for (int i = 0; i < MAX_PARAMS; i++) begin
										if (CNT_W'(i) < cl_cnt) begin
											if (cl_vals[i] == PW'(0)) begin
												cmd.inv_hit = 1'b1;
												cmd.inv = 1'b0;
											end else if (cl_vals[i] == PW'(7)) begin
												cmd.inv_hit = 1'b1;
												cmd.inv = 1'b1;
											end
										end
									end
								end
							end
							default: cmd.kind = aets_pkg::CMD_NONE;
						endcase
					end
					nx_mode = MODE_NORMAL;
					nx_vals = '{default: '0};
					nx_cnt = '0;
					nx_acc = '0;
					nx_active = 1'b0;
				end
			end
			default: nx_mode = MODE_NORMAL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NORMAL;
			for (int i = 0; i < MAX_PARAMS; i++) begin
				vals_q[i] <= '0;
			end
			cnt_q <= '0;
			acc_q <= '0;
			active_q <= 1'b0;
		end else if (feed) begin
			mode_q <= nx_mode;
			vals_q <= nx_vals;
			cnt_q <= nx_cnt;
			acc_q <= nx_acc;
			active_q <= nx_active;
		end
	end

endmodule

/* rtl/aets_ctrl.sv */
module aets_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input aets_pkg::req_item_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output aets_pkg::rsp_item_t rsp,
	input aets_pkg::cmd_t cmd,
	input logic [7:0] normal_attr,
	input logic [7:0] inverse_attr,
	output logic ram_we,
	output logic [aets_pkg::ADDR_W-1:0] ram_waddr,
	output logic [aets_pkg::CELL_W-1:0] ram_wdata,
	output logic [aets_pkg::ADDR_W-1:0] ram_raddr,
	input logic [aets_pkg::CELL_W-1:0] ram_rdata
);

	localparam int AW = aets_pkg::ADDR_W;
	localparam int RW = aets_pkg::ROW_W;
	localparam int CW = aets_pkg::COL_W;
	localparam int ROWS = aets_pkg::SCREEN_ROWS;
	localparam int COLS = aets_pkg::SCREEN_COLS;
	localparam logic [aets_pkg::CELL_W-1:0] INIT_BLANK =
		{aets_pkg::NORMAL_ATTR_RST, aets_pkg::CH_BLANK};

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_FILL = 4'b0010,
		ST_READ = 4'b0100,
		ST_RESULT = 4'b1000
	} ctrl_state_t;

	ctrl_state_t state_q, nx_state;
	logic [RW-1:0] row_q, nx_row, top_q, nx_top, bs_row, rd_row;
	logic [CW-1:0] col_q, nx_col, bs_col, rd_col;
	logic inv_q, nx_inv;
	logic [AW-1:0] fill_addr_q, nx_fill_addr, fill_last_q, nx_fill_last;
	logic fill_init_q, nx_fill_init, fill_bump_q, nx_fill_bump;
	logic [7:0] res_char_q, nx_res_char, res_attr_q, nx_res_attr;
	logic [AW-1:0] cur_base, bs_base, top_base;
	logic [aets_pkg::CELL_W-1:0] blank;
	logic out_load;
	aets_pkg::rsp_item_t rsp_q;
	logic rsp_valid_q;

	// Rows are stored as a ring: logical row 0 lives at physical row top_q.
	function automatic logic [AW-1:0] row_base(input logic [RW-1:0] r, input logic [RW-1:0] t);
		logic [RW:0] s;
		s = {1'b0, r} + {1'b0, t};
		if (s >= (RW + 1)'(ROWS)) begin
			s = s - (RW + 1)'(ROWS);
		end
		return AW'(s) * AW'(COLS);
	endfunction

	assign blank = {normal_attr, aets_pkg::CH_BLANK};
	assign cur_base = row_base(row_q, top_q);
	assign bs_base = row_base(bs_row, top_q);
	assign top_base = row_base(RW'(0), top_q);
	assign rd_row = (req.read_row >= RW'(ROWS)) ? RW'(ROWS - 1) : req.read_row;
	assign rd_col = (req.read_col >= CW'(COLS)) ? CW'(COLS - 1) : req.read_col;
	assign ram_raddr = row_base(rd_row, top_q) + AW'(rd_col);
	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_comb begin
		bs_row = row_q;
		bs_col = col_q;
		if (col_q != '0) begin
			bs_col = col_q - 1'b1;
		end else if (row_q != '0) begin
			bs_row = row_q - 1'b1;
			bs_col = CW'(COLS - 1);
		end
	end

	always_comb begin
		nx_state = state_q;
		nx_row = row_q;
		nx_col = col_q;
		nx_inv = inv_q;
		nx_top = top_q;
		nx_fill_addr = fill_addr_q;
		nx_fill_last = fill_last_q;
		nx_fill_init = fill_init_q;
		nx_fill_bump = fill_bump_q;
		nx_res_char = res_char_q;
		nx_res_attr = res_attr_q;
		ram_we = 1'b0;
		ram_waddr = fill_addr_q;
		ram_wdata = blank;
		out_load = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					nx_res_char = '0;
					nx_res_attr = '0;
					if (req.operation == aets_pkg::OP_READ) begin
						nx_state = ST_READ;
					end else begin
						nx_state = ST_RESULT;
						case (cmd.kind)
							aets_pkg::CMD_PUT: begin
								ram_we = 1'b1;
								ram_waddr = cur_base + AW'(col_q);
								ram_wdata = {inv_q ? inverse_attr : normal_attr, cmd.ch};
								if (col_q == CW'(COLS - 1)) begin
									nx_col = '0;
									if (row_q == RW'(ROWS - 1)) begin
										nx_state = ST_FILL;
										nx_fill_addr = top_base;
										nx_fill_last = top_base + AW'(COLS - 1);
										nx_fill_bump = 1'b1;
									end else begin
										nx_row = row_q + 1'b1;
									end
								end else begin
									nx_col = col_q + 1'b1;
								end
							end
							aets_pkg::CMD_CR: nx_col = '0;
							aets_pkg::CMD_LF: begin
								if (row_q == RW'(ROWS - 1)) begin
									nx_state = ST_FILL;
									nx_fill_addr = top_base;
									nx_fill_last = top_base + AW'(COLS - 1);
									nx_fill_bump = 1'b1;
								end else begin
									nx_row = row_q + 1'b1;
								end
							end
							aets_pkg::CMD_BS: begin
								ram_we = 1'b1;
								ram_waddr = bs_base + AW'(bs_col);
								nx_row = bs_row;
								nx_col = bs_col;
							end
							aets_pkg::CMD_CLEAR: begin
								nx_state = ST_FILL;
								nx_fill_addr = '0;
								nx_fill_last = AW'(aets_pkg::CELLS - 1);
								nx_fill_bump = 1'b0;
								nx_row = '0;
								nx_col = '0;
							end
							aets_pkg::CMD_EL: begin
								nx_state = ST_FILL;
								nx_fill_addr = cur_base + AW'(col_q);
								nx_fill_last = cur_base + AW'(COLS - 1);
								nx_fill_bump = 1'b0;
							end
							aets_pkg::CMD_CUP: begin
								nx_row = cmd.row;
								nx_col = cmd.col;
							end
							aets_pkg::CMD_SGR: begin
								if (cmd.inv_hit) begin
									nx_inv = cmd.inv;
								end
							end
							default: nx_state = ST_RESULT;
						endcase
					end
				end
			end
			ST_FILL: begin
				ram_we = 1'b1;
				ram_waddr = fill_addr_q;
				ram_wdata = fill_init_q ? INIT_BLANK : blank;
				if (fill_addr_q == fill_last_q) begin
					// The clearing pass after reset has no item waiting on it.
					nx_state = fill_init_q ? ST_IDLE : ST_RESULT;
					nx_fill_init = 1'b0;
					nx_fill_bump = 1'b0;
					if (fill_bump_q) begin
						nx_top = (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;
					end
				end else begin
					nx_fill_addr = fill_addr_q + 1'b1;
				end
			end
			ST_READ: begin
				nx_res_char = ram_rdata[7:0];
				nx_res_attr = ram_rdata[15:8];
				nx_state = ST_RESULT;
			end
			ST_RESULT: begin
				if (!rsp_valid_q || rsp_ready) begin
					out_load = 1'b1;
					nx_state = ST_IDLE;
				end
			end
			default: nx_state = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			row_q <= '0;
			col_q <= '0;
			inv_q <= 1'b0;
			top_q <= '0;
			fill_addr_q <= '0;
			fill_last_q <= AW'(aets_pkg::CELLS - 1);
			fill_init_q <= 1'b1;
			fill_bump_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= nx_state;
			row_q <= nx_row;
			col_q <= nx_col;
			inv_q <= nx_inv;
			top_q <= nx_top;
			fill_addr_q <= nx_fill_addr;
			fill_last_q <= nx_fill_last;
			fill_init_q <= nx_fill_init;
			fill_bump_q <= nx_fill_bump;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_char_q <= nx_res_char;
		res_attr_q <= nx_res_attr;
		if (out_load) begin
			rsp_q.cell_char <= res_char_q;
			rsp_q.cell_attr <= res_attr_q;
			rsp_q.cursor_row <= row_q;
			rsp_q.cursor_col <= col_q;
			rsp_q.inverse_on <= inv_q;
		end
	end

endmodule
